@@ rtl/core/ltc_pkg.sv @@
// Shared types and constants for the logic transition capture block.
// No dependencies; imported by ltc_cfg and logic_transition_capture_top.
`default_nettype none

package ltc_pkg;

    localparam int LTC_CHANNELS       = 8;
    localparam int LTC_MAX_CHANNELS   = 8;
    localparam int LTC_PIN_W          = 6;
    localparam int LTC_TICK_W         = 42;
    localparam int LTC_CFG_IDX_W      = 3;
    localparam int LTC_CFG_DATA_W     = 48;

    localparam logic [31:0] LTC_DEF_TIMEOUT_US = 32'd200000;
    localparam logic [31:0] LTC_DEF_CAP_US     = 32'd50000;
    localparam logic [9:0]  LTC_DEF_CPM        = 10'd240;
    localparam logic [15:0] LTC_DEF_MAX_SAMPLES = 16'd4096;

    // register indexes on the configuration port
    localparam logic [LTC_CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [LTC_CFG_IDX_W-1:0] CFG_CHANNEL_PINS  = 3'd1;
    localparam logic [LTC_CFG_IDX_W-1:0] CFG_CYCLES_PER_US = 3'd2;
    localparam logic [LTC_CFG_IDX_W-1:0] CFG_TRIG_TIMEOUT  = 3'd3;
    localparam logic [LTC_CFG_IDX_W-1:0] CFG_HARD_CAP      = 3'd4;
    localparam logic [LTC_CFG_IDX_W-1:0] CFG_IDLE_US       = 3'd5;
    localparam logic [LTC_CFG_IDX_W-1:0] CFG_MAX_SAMPLES   = 3'd6;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } ltc_op_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_INVALID = 2'd3
    } ltc_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_BURST = 2'd2
    } ltc_phase_t;

    // configuration as seen by the capture datapath, limits already in ticks
    typedef struct packed {
        logic [3:0]            channel_count;
        logic [47:0]           channel_pins;
        logic [9:0]            cpm;
        logic [LTC_TICK_W-1:0] timeout_ticks;
        logic [LTC_TICK_W-1:0] cap_ticks;
        logic                  idle_en;
        logic [LTC_TICK_W-1:0] idle_ticks;
        logic [15:0]           max_samples;
    } ltc_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/ltc_cfg.sv @@
// Configuration register file and tick-limit products for the capture block.
// Depends on ltc_pkg.
`default_nettype none

module ltc_cfg
    import ltc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      wr_en,
    input  wire logic [LTC_CFG_IDX_W-1:0]  wr_index,
    input  wire logic [LTC_CFG_DATA_W-1:0] wr_data,
    output ltc_cfg_t                       cfg
);

    logic [3:0]            channel_count_reg;
    logic [47:0]           channel_pins_reg;
    logic [9:0]            cycles_per_us_reg;
    logic [31:0]           timeout_us_reg;
    logic [31:0]           hard_cap_us_reg;
    logic [31:0]           idle_us_reg;
    logic [15:0]           max_samples_reg;

    logic [LTC_TICK_W-1:0] timeout_ticks_reg;
    logic [LTC_TICK_W-1:0] cap_ticks_reg;
    logic [LTC_TICK_W-1:0] idle_ticks_reg;

    logic [9:0]            cpm;
    logic [31:0]           timeout_eff;
    logic [31:0]           cap_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= 4'd1;
            channel_pins_reg  <= '0;
            cycles_per_us_reg <= LTC_DEF_CPM;
            timeout_us_reg    <= '0;
            hard_cap_us_reg   <= '0;
            idle_us_reg       <= '0;
            max_samples_reg   <= LTC_DEF_MAX_SAMPLES;
        end else if (wr_en) begin
            case (wr_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= wr_data[3:0];
                CFG_CHANNEL_PINS:  channel_pins_reg  <= wr_data[47:0];
                CFG_CYCLES_PER_US: cycles_per_us_reg <= wr_data[9:0];
                CFG_TRIG_TIMEOUT:  timeout_us_reg    <= wr_data[31:0];
                CFG_HARD_CAP:      hard_cap_us_reg   <= wr_data[31:0];
                CFG_IDLE_US:       idle_us_reg       <= wr_data[31:0];
                CFG_MAX_SAMPLES:   max_samples_reg   <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign cpm         = (cycles_per_us_reg == '0) ? 10'd1 : cycles_per_us_reg;
    assign timeout_eff = (timeout_us_reg == '0) ? LTC_DEF_TIMEOUT_US : timeout_us_reg;
    assign cap_eff     = (hard_cap_us_reg == '0) ? LTC_DEF_CAP_US : hard_cap_us_reg;

    // 32x10 products, exact in 42 bits; refreshed every cycle. Config must only change
    // while no transaction is in flight; the block itself does not enforce this
    always_ff @(posedge aclk) begin
        timeout_ticks_reg <= LTC_TICK_W'(timeout_eff) * LTC_TICK_W'(cpm);
        cap_ticks_reg     <= LTC_TICK_W'(cap_eff) * LTC_TICK_W'(cpm);
        idle_ticks_reg    <= LTC_TICK_W'(idle_us_reg) * LTC_TICK_W'(cpm);
    end

    always_comb begin
        cfg.channel_count = channel_count_reg;
        cfg.channel_pins  = channel_pins_reg;
        cfg.cpm           = cpm;
        cfg.timeout_ticks = timeout_ticks_reg;
        cfg.cap_ticks     = cap_ticks_reg;
        cfg.idle_en       = (idle_us_reg != '0);
        cfg.idle_ticks    = idle_ticks_reg;
        cfg.max_samples   = max_samples_reg;
    end

endmodule

`default_nettype wire

@@ rtl/core/logic_transition_capture_top.sv @@
// Logic transition capture: input register, then one pass of compare/count logic
// into the result register; both registers hold while the output is stalled.
// Throughput: one transaction per cycle while m_ready keeps the output moving; the
// per-tick state update is combinational, and the result register decouples the output side.
// Reset (aresetn low, synchronous) returns the phase to idle, clears counters and
// restores the configuration defaults.
// Depends on ltc_pkg and ltc_cfg.
`default_nettype none

module logic_transition_capture_top
    import ltc_pkg::*;
#(
    parameter int CHANNELS = LTC_CHANNELS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [LTC_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [LTC_CFG_DATA_W-1:0] cfg_data,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_op,
    input  wire logic [31:0]               s_pins_low,
    input  wire logic [31:0]               s_pins_high,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [1:0]                     m_kind,
    output logic [31:0]                    m_time_us,
    output logic [7:0]                     m_levels,
    output logic [15:0]                    m_count,
    output logic                           m_last
);

    localparam logic [LTC_TICK_W-1:0] TICK_MAX = '1;

    ltc_cfg_t cfg;

    // input stage
    logic        in_valid_reg;
    ltc_op_t     op_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;

    // capture state
    ltc_phase_t            phase_reg, phase_next;
    logic [7:0]            prev_reg, prev_next;
    logic [LTC_TICK_W-1:0] tstart_reg, tstart_next;
    logic [LTC_TICK_W-1:0] tchange_reg, tchange_next;
    logic [9:0]            presc_reg, presc_next;
    logic [31:0]           us_reg, us_next;
    logic [15:0]           cnt_reg, cnt_next;

    // result stage
    logic        out_valid_reg;
    ltc_kind_t   kind_reg, kind_next;
    logic [31:0] time_reg, time_next;
    logic [7:0]  levels_reg, levels_next;
    logic [15:0] count_reg, count_next;
    logic        last_reg, last_next;
    logic        emit;

    logic                  advance;
    logic                  proc;
    logic [7:0]            lv;
    logic                  changed;
    logic                  start_ok;
    logic                  trig_last;
    logic [LTC_TICK_W-1:0] tstart_inc;
    logic [LTC_TICK_W-1:0] tchange_inc;
    logic                  timeout_hit;
    logic                  end_hit;
    logic                  us_wrap;
    logic [15:0]           cnt_inc;
    logic                  burst_last;

    ltc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    assign advance = !out_valid_reg || m_ready;
    assign proc    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= ltc_op_t'(s_op);
            lo_reg <= s_pins_low;
            hi_reg <= s_pins_high;
        end
    end

    // channel gather: each channel picks one of 64 pins, unused channels read 0
    always_comb begin
        logic [5:0] pin;
        lv = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            pin = cfg.channel_pins[LTC_PIN_W*i +: LTC_PIN_W];
            if (4'(i) < cfg.channel_count) begin
                lv[i] = pin[5] ? hi_reg[pin[4:0]] : lo_reg[pin[4:0]];
            end
        end
    end

    assign changed     = (lv != prev_reg);
    assign start_ok    = (cfg.channel_count != '0) && (cfg.channel_count <= 4'(CHANNELS)) &&
                         (cfg.max_samples != '0);
    assign trig_last   = (cfg.max_samples <= 16'd1);
    assign tstart_inc  = (tstart_reg == TICK_MAX) ? tstart_reg :
                         tstart_reg + LTC_TICK_W'(1);
    assign tchange_inc = (tchange_reg == TICK_MAX) ? tchange_reg :
                         tchange_reg + LTC_TICK_W'(1);
    assign timeout_hit = (tstart_inc > cfg.timeout_ticks);
    assign end_hit     = (cfg.idle_en && (tchange_inc > cfg.idle_ticks)) ||
                         (tstart_inc > cfg.cap_ticks);
    assign us_wrap     = ({1'b0, presc_reg} + 11'd1) >= {1'b0, cfg.cpm};
    assign cnt_inc     = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;
    assign burst_last  = (cnt_inc >= cfg.max_samples);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (proc) begin
            if (op_reg == OP_START) begin
                phase_next = start_ok ? PH_WAIT : PH_IDLE;
            end else begin
                case (phase_reg)
                    PH_WAIT: begin
                        if (changed) begin
                            phase_next = trig_last ? PH_IDLE : PH_BURST;
                        end else if (timeout_hit) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_BURST: begin
                        if (changed) begin
                            if (burst_last) phase_next = PH_IDLE;
                        end else if (end_hit) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // counters and result
    always_comb begin
        prev_next    = prev_reg;
        tstart_next  = tstart_reg;
        tchange_next = tchange_reg;
        presc_next   = presc_reg;
        us_next      = us_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        kind_next    = KIND_SAMPLE;
        time_next    = '0;
        levels_next  = '0;
        count_next   = '0;
        last_next    = 1'b0;
        if (proc) begin
            if (op_reg == OP_START) begin
                if (!start_ok) begin
                    emit      = 1'b1;
                    kind_next = KIND_INVALID;
                    last_next = 1'b1;
                end else begin
                    prev_next    = lv;
                    tstart_next  = '0;
                    tchange_next = '0;
                    presc_next   = '0;
                    us_next      = '0;
                    cnt_next     = '0;
                end
            end else begin
                case (phase_reg)
                    PH_WAIT: begin
                        if (changed) begin
                            // trigger tick is the sample at time zero
                            prev_next    = lv;
                            tstart_next  = '0;
                            tchange_next = '0;
                            presc_next   = '0;
                            us_next      = '0;
                            cnt_next     = 16'd1;
                            emit         = 1'b1;
                            levels_next  = lv;
                            count_next   = 16'd1;
                            last_next    = trig_last;
                        end else begin
                            tstart_next = tstart_inc;
                            if (timeout_hit) begin
                                emit      = 1'b1;
                                kind_next = KIND_TIMEOUT;
                                last_next = 1'b1;
                            end
                        end
                    end
                    PH_BURST: begin
                        tstart_next  = tstart_inc;
                        tchange_next = tchange_inc;
                        if (us_wrap) begin
                            presc_next = '0;
                            if (us_reg != 32'hFFFF_FFFF) us_next = us_reg + 32'd1;
                        end else begin
                            presc_next = presc_reg + 10'd1;
                        end
                        if (changed) begin
                            prev_next    = lv;
                            tchange_next = '0;
                            cnt_next     = cnt_inc;
                            emit         = 1'b1;
                            time_next    = us_next;
                            levels_next  = lv;
                            count_next   = cnt_inc;
                            last_next    = burst_last;
                        end else if (end_hit) begin
                            emit       = 1'b1;
                            kind_next  = KIND_DONE;
                            count_next = cnt_reg;
                            last_next  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            prev_reg    <= '0;
            tstart_reg  <= '0;
            tchange_reg <= '0;
            presc_reg   <= '0;
            us_reg      <= '0;
            cnt_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            tstart_reg  <= tstart_next;
            tchange_reg <= tchange_next;
            presc_reg   <= presc_next;
            us_reg      <= us_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg   <= kind_next;
            time_reg   <= time_next;
            levels_reg <= levels_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_kind    = kind_reg;
    assign m_time_us = time_reg;
    assign m_levels  = levels_reg;
    assign m_count   = count_reg;
    assign m_last    = last_reg;

    // every non-sample result closes the capture
    a_nonsample_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind != KIND_SAMPLE)) |-> m_last)
        else $error("non-sample result without last");

    // a transaction that ends the capture leaves the block idle
    a_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_next) |=> (phase_reg == PH_IDLE))
        else $error("capture still running after last result");

    // the trigger sample is always counted before the burst runs
    a_burst_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BURST) |-> (cnt_reg != '0))
        else $error("burst with zero sample count");

    // timeout and invalid results carry no count
    a_fail_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_kind == KIND_TIMEOUT) || (m_kind == KIND_INVALID)))
            |-> (m_count == '0))
        else $error("failure result with nonzero count");

endmodule

`default_nettype wire
